// ===== rtl/pnst_pkg.sv =====
// Shared types, constants and codes for the polyline nearest-segment target block.
// Used by the path memory, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pnst_pkg;

    localparam int MAX_POINTS      = 1024;
    localparam int COORD_FRAC_BITS = 16;
    localparam int ADDR_W          = $clog2(MAX_POINTS);
    localparam int CNT_W           = ADDR_W + 1;
    localparam int IDX_OUT_W       = 10;
    localparam int ACC_W           = 27;

    localparam logic [63:0] DEGEN_THRESH =
        64'(((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999) / 64'd1000000);

    localparam logic [ACC_W-1:0] WIDE_STEP = ACC_W'(32'd16777216);

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic REG_LOOP_TOL  = 1'b0;
    localparam logic REG_LOOKAHEAD = 1'b1;

    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_FOUND  = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] yaw;
    } point_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        point_t            pt;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pnst_path_mem.sv =====
// Path point store: one write port and one read port with a registered read.
// Depends on pnst_pkg for the point and write-request types.
`timescale 1ns / 1ps
`default_nettype none

module pnst_path_mem (
    input  wire logic                          clk,
    input  wire pnst_pkg::mem_wr_t             wr,
    input  wire logic [pnst_pkg::ADDR_W-1:0]   rd_addr,
    output pnst_pkg::point_t                   rd_data
);
    import pnst_pkg::*;

    point_t mem [MAX_POINTS];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.pt;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pnst_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module pnst_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= value;
            res_reg <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

// ===== rtl/pnst_sqdiv.sv =====
// Restoring divider for a 128-bit dividend by a 64-bit divisor, one bit per cycle.
// Depends on nothing beyond the clock and reset; the quotient must fit 64 bits.
`timescale 1ns / 1ps
`default_nettype none

module pnst_sqdiv (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] dividend,
    input  wire logic [63:0]  divisor,
    output logic              done,
    output logic [63:0]       quotient
);
    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   count_reg;
    logic [127:0] dvd_reg;
    logic [63:0]  den_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic [63:0]  shifted;

    assign shifted = {rem_reg[62:0], dvd_reg[127]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 7'd1;
                if (count_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= 64'd0;
            q_reg   <= 64'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (shifted >= den_reg)
            begin
                rem_reg <= shifted - den_reg;
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/polyline_nearest_segment_target.sv =====
// Polyline nearest-segment target selector: a path store, a segment scan sequencer with one
// shared multiplier, a divider and a square-root unit. Depends on pnst_pkg, pnst_path_mem,
// pnst_sqrt and pnst_sqdiv.
//
// Point items (new path, append) go straight from the idle state to the finish state. A pose
// query reads two points per segment through the single read port of the path memory and
// runs ten multiplies on the shared multiplier per segment, plus a pass through the divider
// when the projection falls inside the segment. The scan covers the segments from the saved
// closest index to the end. On a loop path each lookahead walk step over a chord that is not
// wide is bounded by the square-root unit. One item is worked at a time; a new item is taken
// while the previous result still waits at the output register.
`timescale 1ns / 1ps
`default_nettype none

module polyline_nearest_segment_target (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [15:0] point_yaw,
    input  wire logic signed [31:0] pose_x,
    input  wire logic signed [31:0] pose_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      target_x,
    output logic signed [31:0]      target_y,
    output logic signed [15:0]      target_yaw,
    output logic [9:0]              nearest_index
);
    import pnst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SEG_RA, S_SEG_RB, S_SEG_RC, S_SEG_DIFF, S_SEG_MUL, S_SEG_DEC, S_SEG_SQ,
        S_SEG_DIVGO, S_SEG_DIV, S_SEG_CMP, S_LOOP_RA, S_LOOP_RB, S_LOOP_RC, S_LOOP_DIFF,
        S_LOOP_MUL, S_LOOP_DEC, S_WALK_CHK, S_WALK_RB, S_WALK_RC, S_WALK_DIFF, S_WALK_MUL,
        S_WALK_SQGO, S_WALK_SQRT, S_WALK_NEXT, S_TGT, S_TGT_RD, S_FIN
    } state_t;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (d < -33'sd2147483647)
            return 32'sh80000001;
        else
            return d[31:0];
    endfunction

    function automatic logic is_wide(input logic signed [32:0] d);
        return (d >= 33'sd16777216) || (d <= -33'sd16777216);
    endfunction

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  cs_reg;
    logic [23:0]        tol_reg;
    logic [23:0]        la_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [63:0]        best_reg;
    logic [ADDR_W-1:0]  best_i_reg;
    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [31:0] ex_reg, ey_reg, dx_reg, dy_reg, fx_reg, fy_reg;
    logic signed [32:0] wdx_reg, wdy_reg;
    logic               wide_reg;
    logic [3:0]         m_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        e2_reg, den_reg, f2_reg, mag_reg, dval_reg;
    logic signed [63:0] num_reg, cr_reg;
    logic [127:0]       sq_reg;
    logic [ADDR_W-1:0]  idx_reg, tgt_reg;
    logic [CNT_W-1:0]   steps_reg;
    logic [ACC_W-1:0]   acc_reg;
    status_t            res_status_reg;
    point_t             res_pt_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    point_t             out_pt_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;

    mem_wr_t            mem_wr;
    logic [ADDR_W-1:0]  rd_addr;
    point_t             rd_data;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic               accept;
    logic [ADDR_W-1:0]  l_addr;
    logic [CNT_W-1:0]   eff;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   i_next;
    logic               last_seg;
    logic [ADDR_W-1:0]  nxt;
    logic [ADDR_W-1:0]  cs_fix;
    logic               div_start, div_done;
    logic [63:0]        div_q;
    logic               sqrt_start, sqrt_done;
    logic [31:0]        sqrt_root;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign l_addr   = ADDR_W'(cnt_reg - 1'b1);
    assign eff      = cnt_reg - 1'b1;
    assign limit    = (cnt_reg > CNT_W'(1)) ? eff : CNT_W'(1);
    assign i_next   = i_reg + 1'b1;
    assign last_seg = (i_next >= cnt_reg);
    assign nxt      = ((CNT_W'(idx_reg) + 1'b1) == eff) ? '0 : ADDR_W'(idx_reg + 1'b1);
    assign cs_fix   = (CNT_W'(cs_reg) >= cnt_reg) ? '0 : cs_reg;
    assign div_start  = (state_reg == S_SEG_DIVGO);
    assign sqrt_start = (state_reg == S_WALK_SQGO);

    always_comb
    begin
        mem_wr.en     = accept && ((opcode == OP_NEW) ||
                        (opcode == OP_APPEND && cnt_reg < CNT_W'(MAX_POINTS)));
        mem_wr.addr   = (opcode == OP_NEW) ? '0 : ADDR_W'(cnt_reg);
        mem_wr.pt.x   = point_x;
        mem_wr.pt.y   = point_y;
        mem_wr.pt.yaw = point_yaw;
    end

    always_comb
    begin
        unique case (state_reg)
            S_SEG_RA:   rd_addr = last_seg ? l_addr : ADDR_W'(i_reg);
            S_SEG_RB:   rd_addr = last_seg ? l_addr : ADDR_W'(i_next);
            S_LOOP_RA:  rd_addr = '0;
            S_LOOP_RB:  rd_addr = l_addr;
            S_WALK_CHK: rd_addr = idx_reg;
            S_WALK_RB:  rd_addr = nxt;
            S_TGT:      rd_addr = tgt_reg;
            default:    rd_addr = '0;
        endcase
    end

    always_comb
    begin
        mul_a = 33'(ex_reg);
        mul_b = 33'(ex_reg);
        unique case (state_reg)
            S_SEG_MUL:
            begin
                unique case (m_reg)
                    4'd1:    begin mul_a = 33'(ey_reg); mul_b = 33'(ey_reg); end
                    4'd2:    begin mul_a = 33'(dx_reg); mul_b = 33'(dx_reg); end
                    4'd3:    begin mul_a = 33'(dy_reg); mul_b = 33'(dy_reg); end
                    4'd4:    begin mul_a = 33'(ex_reg); mul_b = 33'(dx_reg); end
                    4'd5:    begin mul_a = 33'(ey_reg); mul_b = 33'(dy_reg); end
                    4'd6:    begin mul_a = 33'(ex_reg); mul_b = 33'(dy_reg); end
                    4'd7:    begin mul_a = 33'(ey_reg); mul_b = 33'(dx_reg); end
                    4'd8:    begin mul_a = 33'(fx_reg); mul_b = 33'(fx_reg); end
                    4'd9:    begin mul_a = 33'(fy_reg); mul_b = 33'(fy_reg); end
                    default: begin mul_a = 33'(ex_reg); mul_b = 33'(ex_reg); end
                endcase
            end
            S_SEG_SQ:
            begin
                mul_a = $signed({1'b0, mag_reg[31:0]});
                mul_b = $signed({1'b0, mag_reg[31:0]});
                if (m_reg == 4'd1)
                    mul_a = $signed({1'b0, mag_reg[63:32]});
                else if (m_reg >= 4'd2)
                begin
                    mul_a = $signed({1'b0, mag_reg[63:32]});
                    mul_b = $signed({1'b0, mag_reg[63:32]});
                end
            end
            S_LOOP_MUL, S_WALK_MUL:
            begin
                mul_a = wdx_reg;
                mul_b = wdx_reg;
                if (m_reg == 4'd1)
                begin
                    mul_a = wdy_reg;
                    mul_b = wdy_reg;
                end
                else if (m_reg >= 4'd2)
                begin
                    mul_a = $signed({9'd0, tol_reg});
                    mul_b = $signed({9'd0, tol_reg});
                end
            end
            default:
            begin
                mul_a = 33'(ex_reg);
                mul_b = 33'(ex_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOOKAHEAD) ? {8'd0, la_reg} : {8'd0, tol_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 24'd13107;
            la_reg  <= 24'd65536;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_LOOP_TOL)
                tol_reg <= pwdata[23:0];
            else
                la_reg <= pwdata[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_pt_reg <= '0;
                        state_reg  <= S_FIN;
                        unique case (opcode)
                            OP_NEW:
                            begin
                                cnt_reg        <= CNT_W'(1);
                                cs_reg         <= '0;
                                res_status_reg <= STAT_STORED;
                            end
                            OP_APPEND:
                            begin
                                if (cnt_reg < CNT_W'(MAX_POINTS))
                                begin
                                    cnt_reg        <= cnt_reg + 1'b1;
                                    res_status_reg <= STAT_STORED;
                                end
                                else
                                    res_status_reg <= STAT_FULL;
                            end
                            OP_QUERY:
                            begin
                                res_status_reg <= STAT_NONE;
                                if (cnt_reg != '0)
                                begin
                                    qx_reg     <= pose_x;
                                    qy_reg     <= pose_y;
                                    cs_reg     <= cs_fix;
                                    i_reg      <= CNT_W'(cs_fix);
                                    best_reg   <= '1;
                                    best_i_reg <= cs_fix;
                                    state_reg  <= S_SEG_RA;
                                end
                            end
                            default:
                                res_status_reg <= STAT_NONE;
                        endcase
                    end
                end
                S_SEG_RA:
                    state_reg <= S_SEG_RB;
                S_SEG_RB:
                begin
                    x0_reg    <= rd_data.x;
                    y0_reg    <= rd_data.y;
                    state_reg <= S_SEG_RC;
                end
                S_SEG_RC:
                begin
                    x1_reg    <= rd_data.x;
                    y1_reg    <= rd_data.y;
                    state_reg <= S_SEG_DIFF;
                end
                S_SEG_DIFF:
                begin
                    ex_reg    <= sat_diff(qx_reg, x0_reg);
                    ey_reg    <= sat_diff(qy_reg, y0_reg);
                    dx_reg    <= sat_diff(x1_reg, x0_reg);
                    dy_reg    <= sat_diff(y1_reg, y0_reg);
                    fx_reg    <= sat_diff(qx_reg, x1_reg);
                    fy_reg    <= sat_diff(qy_reg, y1_reg);
                    m_reg     <= '0;
                    state_reg <= S_SEG_MUL;
                end
                S_SEG_MUL:
                begin
                    prod_reg <= mul_p[63:0];
                    unique case (m_reg)
                        4'd1:    e2_reg  <= prod_reg;
                        4'd2:    e2_reg  <= e2_reg + prod_reg;
                        4'd3:    den_reg <= prod_reg;
                        4'd4:    den_reg <= den_reg + prod_reg;
                        4'd5:    num_reg <= $signed(prod_reg);
                        4'd6:    num_reg <= num_reg + $signed(prod_reg);
                        4'd7:    cr_reg  <= $signed(prod_reg);
                        4'd8:    cr_reg  <= cr_reg - $signed(prod_reg);
                        4'd9:    f2_reg  <= prod_reg;
                        4'd10:   f2_reg  <= f2_reg + prod_reg;
                        default: ;
                    endcase
                    m_reg <= m_reg + 4'd1;
                    if (m_reg == 4'd10)
                        state_reg <= S_SEG_DEC;
                end
                S_SEG_DEC:
                begin
                    priority if (den_reg < DEGEN_THRESH || num_reg <= 64'sd0)
                    begin
                        dval_reg  <= e2_reg;
                        state_reg <= S_SEG_CMP;
                    end
                    else if (num_reg >= $signed(den_reg))
                    begin
                        dval_reg  <= f2_reg;
                        state_reg <= S_SEG_CMP;
                    end
                    else
                    begin
                        mag_reg   <= (cr_reg < 64'sd0) ? 64'(-cr_reg) : 64'(cr_reg);
                        m_reg     <= '0;
                        state_reg <= S_SEG_SQ;
                    end
                end
                S_SEG_SQ:
                begin
                    prod_reg <= mul_p[63:0];
                    m_reg    <= m_reg + 4'd1;
                    if (m_reg == 4'd1)
                        sq_reg <= 128'(prod_reg);
                    else if (m_reg == 4'd2)
                        sq_reg <= sq_reg + (128'(prod_reg) << 33);
                    else if (m_reg == 4'd3)
                    begin
                        sq_reg    <= sq_reg + (128'(prod_reg) << 64);
                        state_reg <= S_SEG_DIVGO;
                    end
                end
                S_SEG_DIVGO:
                    state_reg <= S_SEG_DIV;
                S_SEG_DIV:
                begin
                    if (div_done)
                    begin
                        dval_reg  <= div_q;
                        state_reg <= S_SEG_CMP;
                    end
                end
                S_SEG_CMP:
                begin
                    if (dval_reg < best_reg)
                    begin
                        best_reg   <= dval_reg;
                        best_i_reg <= ADDR_W'(i_reg);
                    end
                    if (i_next < limit)
                    begin
                        i_reg     <= i_next;
                        state_reg <= S_SEG_RA;
                    end
                    else
                    begin
                        cs_reg    <= (dval_reg < best_reg) ? ADDR_W'(i_reg) : best_i_reg;
                        state_reg <= S_LOOP_RA;
                    end
                end
                S_LOOP_RA:
                begin
                    if (cnt_reg > CNT_W'(2))
                        state_reg <= S_LOOP_RB;
                    else
                    begin
                        tgt_reg   <= l_addr;
                        state_reg <= S_TGT;
                    end
                end
                S_LOOP_RB:
                begin
                    x0_reg    <= rd_data.x;
                    y0_reg    <= rd_data.y;
                    state_reg <= S_LOOP_RC;
                end
                S_LOOP_RC, S_WALK_RC:
                begin
                    x1_reg    <= rd_data.x;
                    y1_reg    <= rd_data.y;
                    state_reg <= (state_reg == S_LOOP_RC) ? S_LOOP_DIFF : S_WALK_DIFF;
                end
                S_LOOP_DIFF, S_WALK_DIFF:
                begin
                    wdx_reg   <= 33'(x1_reg) - 33'(x0_reg);
                    wdy_reg   <= 33'(y1_reg) - 33'(y0_reg);
                    wide_reg  <= is_wide(33'(x1_reg) - 33'(x0_reg)) ||
                                 is_wide(33'(y1_reg) - 33'(y0_reg));
                    m_reg     <= '0;
                    state_reg <= (state_reg == S_LOOP_DIFF) ? S_LOOP_MUL : S_WALK_MUL;
                end
                S_LOOP_MUL:
                begin
                    prod_reg <= mul_p[63:0];
                    m_reg    <= m_reg + 4'd1;
                    if (m_reg == 4'd1)
                        e2_reg <= prod_reg;
                    else if (m_reg == 4'd2)
                        e2_reg <= e2_reg + prod_reg;
                    else if (m_reg == 4'd3)
                    begin
                        f2_reg    <= prod_reg;
                        state_reg <= S_LOOP_DEC;
                    end
                end
                S_LOOP_DEC:
                begin
                    if (!wide_reg && e2_reg <= f2_reg && la_reg != 24'd0)
                    begin
                        idx_reg   <= (CNT_W'(cs_reg) == eff) ? '0 : cs_reg;
                        steps_reg <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_WALK_CHK;
                    end
                    else
                    begin
                        tgt_reg   <= l_addr;
                        state_reg <= S_TGT;
                    end
                end
                S_WALK_CHK:
                begin
                    if (steps_reg < eff && acc_reg < ACC_W'(la_reg))
                        state_reg <= S_WALK_RB;
                    else
                    begin
                        tgt_reg   <= idx_reg;
                        state_reg <= S_TGT;
                    end
                end
                S_WALK_RB:
                begin
                    x0_reg    <= rd_data.x;
                    y0_reg    <= rd_data.y;
                    state_reg <= S_WALK_RC;
                end
                S_WALK_MUL:
                begin
                    prod_reg <= mul_p[63:0];
                    m_reg    <= m_reg + 4'd1;
                    if (m_reg == 4'd1)
                        e2_reg <= prod_reg;
                    else if (m_reg == 4'd2)
                    begin
                        e2_reg <= e2_reg + prod_reg;
                        if (wide_reg)
                        begin
                            acc_reg   <= acc_reg + WIDE_STEP;
                            state_reg <= S_WALK_NEXT;
                        end
                        else
                            state_reg <= S_WALK_SQGO;
                    end
                end
                S_WALK_SQGO:
                    state_reg <= S_WALK_SQRT;
                S_WALK_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        acc_reg   <= acc_reg + ACC_W'(sqrt_root);
                        state_reg <= S_WALK_NEXT;
                    end
                end
                S_WALK_NEXT:
                begin
                    idx_reg   <= nxt;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_WALK_CHK;
                end
                S_TGT:
                    state_reg <= S_TGT_RD;
                S_TGT_RD:
                begin
                    res_pt_reg     <= rd_data;
                    res_status_reg <= STAT_FOUND;
                    state_reg      <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_pt_reg     <= res_pt_reg;
                        out_idx_reg    <= IDX_OUT_W'(cs_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    pnst_path_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pnst_sqdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sq_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    pnst_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (e2_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign target_x      = out_pt_reg.x;
    assign target_y      = out_pt_reg.y;
    assign target_yaw    = out_pt_reg.yaw;
    assign nearest_index = out_idx_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds the store depth");

    a_closest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) || (CNT_W'(cs_reg) < cnt_reg))
        else $error("closest index lies beyond the stored points");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> (state_reg == S_IDLE))
        else $error("path store written during a query");

    a_found_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TGT_RD) |=> (res_status_reg == STAT_FOUND) && (state_reg == S_FIN))
        else $error("target read did not complete the query");
`endif

endmodule

`default_nettype wire

// ===== test/polyline_nearest_segment_target_test.sv =====
// Self-checking testbench for polyline_nearest_segment_target: builds paths, runs pose queries
// and compares every result with an in-bench prediction of the path store and segment scan.
// Depends on pnst_pkg and the polyline_nearest_segment_target RTL.
`timescale 1ns / 1ps

module polyline_nearest_segment_target_test;

    import pnst_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam logic [2:0] ADDR_LOOP_TOL  = 3'd0;
    localparam logic [2:0] ADDR_LOOKAHEAD = 3'd4;
    localparam logic [1:0] OP_BAD = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] pyaw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } path_item_t;

    typedef struct packed {
        logic [1:0]         st;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] yaw;
        logic [9:0]         idx;
    } target_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic [1:0] opcode = '0;
    logic signed [31:0] point_x = '0, point_y = '0, pose_x = '0, pose_y = '0;
    logic signed [15:0] point_yaw = '0;
    logic out_valid, out_ready = 1'b0;
    logic [1:0] status;
    logic signed [31:0] target_x, target_y;
    logic signed [15:0] target_yaw;
    logic [9:0] nearest_index;

    polyline_nearest_segment_target i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .point_x(point_x), .point_y(point_y), .point_yaw(point_yaw),
        .pose_x(pose_x), .pose_y(pose_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .target_x(target_x), .target_y(target_y),
        .target_yaw(target_yaw), .nearest_index(nearest_index)
    );

    path_item_t pending_items[$];
    target_t    expected_targets[$];
    path_item_t cur_item;

    longint          path_xs[MAX_POINTS];
    longint          path_ys[MAX_POINTS];
    logic [15:0]     path_yaws[MAX_POINTS];
    int              n_pts = 0;
    int              near_seg = 0;
    longint unsigned tol_shadow = 13107;
    longint unsigned look_shadow = 65536;

    bit   jitter = 1'b1;
    int   in_gap = 0, out_gap = 0, hold_left = 0;
    int   hold_req = 0, hold_ack = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic longint clip_diff(longint a, longint b);
        longint d;
        d = a - b;
        if (d > 64'sd2147483647) return 64'sd2147483647;
        if (d < -64'sd2147483647) return -64'sd2147483647;
        return d;
    endfunction

    function automatic longint unsigned norm2(longint a, longint b);
        return longint'(a * a) + longint'(b * b);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned segment_dist2(int i, longint qx, longint qy);
        longint ex, ey, dx, dy, num, crs;
        longint unsigned den, m;
        logic [127:0] prod, quo;
        if (i + 1 >= n_pts)
            return norm2(clip_diff(qx, path_xs[n_pts-1]), clip_diff(qy, path_ys[n_pts-1]));
        ex = clip_diff(qx, path_xs[i]);
        ey = clip_diff(qy, path_ys[i]);
        dx = clip_diff(path_xs[i+1], path_xs[i]);
        dy = clip_diff(path_ys[i+1], path_ys[i]);
        den = norm2(dx, dy);
        if (den < DEGEN_THRESH) return norm2(ex, ey);
        num = ex * dx + ey * dy;
        if (num <= 0) return norm2(ex, ey);
        if (num >= longint'(den))
            return norm2(clip_diff(qx, path_xs[i+1]), clip_diff(qy, path_ys[i+1]));
        crs = ex * dy - ey * dx;
        m = (crs < 0) ? longint'(-crs) : crs;
        prod = {64'd0, m} * {64'd0, m};
        quo = prod / {64'd0, den};
        return quo[63:0];
    endfunction

    function automatic longint unsigned chord_dist2(int a, int b);
        longint dx, dy;
        dx = path_xs[b] - path_xs[a];
        dy = path_ys[b] - path_ys[a];
        if (dx >= 16777216 || dx <= -16777216 || dy >= 16777216 || dy <= -16777216)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return norm2(dx, dy);
    endfunction

    function automatic void store_path_point(path_item_t it);
        path_xs[n_pts] = longint'(it.px);
        path_ys[n_pts] = longint'(it.py);
        path_yaws[n_pts] = it.pyaw;
        n_pts++;
    endfunction

    function automatic void track_item(path_item_t it);
        target_t r;
        int lim, bi, k, eff, idx, steps, tgt;
        longint unsigned best, d, acc, c2;
        bit is_loop;
        r = '0;
        r.st = STAT_NONE;
        if (it.op == OP_NEW) begin
            n_pts = 0;
            near_seg = 0;
            store_path_point(it);
            r.st = STAT_STORED;
        end
        else if (it.op == OP_APPEND) begin
            if (n_pts < MAX_POINTS) begin
                store_path_point(it);
                r.st = STAT_STORED;
            end
            else r.st = STAT_FULL;
        end
        else if (it.op == OP_QUERY && n_pts > 0) begin
            lim = (n_pts > 1) ? n_pts - 1 : 1;
            if (near_seg >= n_pts) near_seg = 0;
            best = 64'hFFFF_FFFF_FFFF_FFFF;
            bi = near_seg;
            for (k = near_seg; k < lim; k++) begin
                d = segment_dist2(k, it.qx, it.qy);
                if (d < best) begin
                    best = d;
                    bi = k;
                end
            end
            near_seg = bi;
            is_loop = 1'b0;
            if (n_pts > 2) begin
                c2 = chord_dist2(0, n_pts - 1);
                is_loop = (c2 != 64'hFFFF_FFFF_FFFF_FFFF) && (c2 <= tol_shadow * tol_shadow);
            end
            if (is_loop && look_shadow > 0) begin
                eff = n_pts - 1;
                idx = near_seg % eff;
                steps = 0;
                acc = 0;
                while (steps < eff && acc < look_shadow) begin
                    c2 = chord_dist2(idx, (idx + 1) % eff);
                    acc += (c2 == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd16777216 : root_floor(c2);
                    idx = (idx + 1) % eff;
                    steps++;
                end
                tgt = idx;
            end
            else tgt = n_pts - 1;
            r.st = STAT_FOUND;
            r.x = 32'(path_xs[tgt]);
            r.y = 32'(path_ys[tgt]);
            r.yaw = path_yaws[tgt];
        end
        r.idx = near_seg[9:0];
        expected_targets = {expected_targets, r};
    endfunction

    // Sender: holds an offered item until it is taken, otherwise idles in short bursts.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) track_item(cur_item);
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (jitter && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    opcode <= cur_item.op;
                    point_x <= cur_item.px;
                    point_y <= cur_item.py;
                    point_yaw <= cur_item.pyaw;
                    pose_x <= cur_item.qx;
                    pose_y <= cur_item.qy;
                    in_valid <= 1'b1;
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_left <= 300;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (jitter && $urandom_range(0, 5) == 0) begin
                out_gap <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        target_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_targets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: status %0d", status);
            end
            else begin
                want = expected_targets.pop_front();
                if (status !== want.st || target_x !== want.x || target_y !== want.y ||
                    target_yaw !== want.yaw || nearest_index !== want.idx) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected st %0d x %0d y %0d yaw %0d idx %0d",
                                 want.st, want.x, want.y, want.yaw, want.idx);
                        $display("          got st %0d x %0d y %0d yaw %0d idx %0d",
                                 status, target_x, target_y, target_yaw, nearest_index);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("polyline_nearest_segment_target_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LOOP_TOL) tol_shadow = value[23:0];
        else look_shadow = value[23:0];
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || in_valid || expected_targets.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic void add_item(logic [1:0] op, longint px, longint py, int yaw,
                                     longint qx, longint qy);
        path_item_t it;
        it.op = op;
        it.px = 32'(px);
        it.py = 32'(py);
        it.pyaw = 16'(yaw);
        it.qx = 32'(qx);
        it.qy = 32'(qy);
        pending_items = {pending_items, it};
    endfunction

    function automatic int rand_yaw();
        return int'($urandom_range(0, 51472)) - 25736;
    endfunction

    function automatic int rand_step();
        return int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
    endfunction

    // A path of random shape, closed to within 40 raw units per axis when asked, then some queries.
    function automatic void add_path(int pts, bit closed, int queries);
        int k, x0, y0, x, y;
        x0 = rand_step() * 4;
        y0 = rand_step() * 4;
        x = x0;
        y = y0;
        add_item(OP_NEW, x, y, rand_yaw(), $urandom, $urandom);
        for (k = 1; k < pts; k++) begin
            if (closed && k == pts - 1) begin
                x = x0 + $urandom_range(0, 40);
                y = y0 - $urandom_range(0, 40);
            end
            else begin
                x += rand_step();
                y += rand_step();
            end
            add_item(OP_APPEND, x, y, rand_yaw(), $urandom, $urandom);
        end
        for (k = 0; k < queries; k++)
            add_item(OP_QUERY, $urandom, $urandom, rand_yaw(),
                     x0 + rand_step() * 2, y0 + rand_step() * 2);
    endfunction

    initial begin
        int k, p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty query, unknown opcode, extremes, single point, degenerate segment.
        add_item(OP_QUERY, 0, 0, 0, 0, 0);
        add_item(OP_BAD, -1, -1, -1, -1, -1);
        add_item(OP_APPEND, 32'sh7FFFFFFF, -32'sh80000000, 25736, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, -32'sh80000000, 32'sh7FFFFFFF);
        add_item(OP_NEW, -32'sh80000000, 32'sh7FFFFFFF, -25736, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 32'sh7FFFFFFF, -32'sh80000000);
        add_item(OP_APPEND, -32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0);
        add_item(OP_APPEND, 0, 0, 1, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 100, -100);
        add_item(OP_NEW, 0, 0, 100, 0, 0);
        add_item(OP_APPEND, 65536 * 4, 0, 200, 0, 0);
        add_item(OP_APPEND, 65536 * 4, 65536 * 4, 300, 0, 0);
        add_item(OP_APPEND, 5, 3, 400, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, -65536, -65536);
        add_item(OP_QUERY, 0, 0, 0, 65536 * 2, 1000);
        add_item(OP_QUERY, 0, 0, 0, 65536 * 9, 65536 * 9);
        add_item(OP_QUERY, 0, 0, 0, 10, 10);
        drain();

        write_reg(ADDR_LOOKAHEAD, 32'd0);
        add_item(OP_QUERY, 0, 0, 0, 3, 3);
        drain();
        write_reg(ADDR_LOOP_TOL, 32'hFFFFFFFF);
        write_reg(ADDR_LOOKAHEAD, 32'h00FFFFFF);
        add_item(OP_QUERY, 0, 0, 0, 65536 * 4, 7);
        add_item(OP_BAD, 0, 0, 0, 0, 0);
        drain();
        write_reg(ADDR_LOOP_TOL, 32'd0);
        write_reg(ADDR_LOOKAHEAD, 32'd1);
        add_item(OP_QUERY, 0, 0, 0, 0, 0);
        drain();

        // Random paths in phases, each phase with its own register setting.
        for (p = 0; p < 4; p++) begin
            write_reg(ADDR_LOOP_TOL, (p == 3) ? 32'h00FFFFFF : $urandom_range(60, 200000));
            write_reg(ADDR_LOOKAHEAD, (p == 0) ? 32'd0 : $urandom_range(1, 16 * 65536));
            if (p == 1) hold_req++;
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(0, 5) == 0)
                    add_item($urandom_range(0, 3), $urandom, $urandom, rand_yaw(),
                             $urandom, $urandom);
                else
                    add_path($urandom_range(1, 9), $urandom_range(0, 2) != 0,
                             $urandom_range(1, 4));
            end
            drain();
        end

        // A longer closed path, one more append, then a query over every segment.
        write_reg(ADDR_LOOP_TOL, 32'd13107);
        write_reg(ADDR_LOOKAHEAD, 32'd65536);
        add_path(20, 1'b1, 0);
        add_item(OP_APPEND, 1, 2, 3, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 65536, 65536);
        drain();

        jitter = 1'b0;
        for (k = 0; k < 3; k++) add_path($urandom_range(3, 6), 1'b1, 2);
        drain();
        repeat (50) @(posedge clk);

        if (mismatches == 0 && expected_targets.size() == 0)
            $display("polyline_nearest_segment_target_test OK");
        else
            $display("polyline_nearest_segment_target_test NOT OK");
        $finish;
    end

endmodule
